@@ rtl/pcmr_pkg.sv @@
package pcmr_pkg;

    localparam int MAX_FRAMES  = 1048576;
    localparam int MAX_RESULTS = 52;
    localparam int FRAME_W     = $clog2(MAX_FRAMES);
    localparam int RATE_W      = 18;
    localparam int SAMPLE_W    = 16;
    localparam int FRAC_W      = 32;
    localparam int STEP_W      = RATE_W + FRAC_W;
    localparam int POS_W       = 64;
    localparam int TOT_W       = FRAME_W + 1 + RATE_W + 1;
    localparam int EMIT_W      = 42;
    localparam int N_W         = $clog2(MAX_RESULTS + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int FIFO_DEPTH  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IN_RATE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_RATE = 2'd3;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);
    localparam logic [7:0]        U8_BIAS    = 8'h80;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] l;
        logic signed [SAMPLE_W-1:0] r;
        logic                       last;
        logic [FRAME_W-1:0]         k;
    } item_t;

    typedef struct packed {
        logic [RATE_W-1:0] rin;
        logic [RATE_W-1:0] rout;
        logic              chg;
    } rate_t;

endpackage

@@ rtl/pcm_convert_linear_resampler.sv @@
// Channel | Dir | Signals                                  | Payload
// s       | in  | s_tvalid s_tready s_tdata s_tlast        | first/second_sample; last_frame
// m       | out | m_tvalid m_tready m_tdata m_tlast m_tuser | left/right_out; run_end; buffer_end
// cfg     | in  | cfg_en cfg_index cfg_data                | register write, no read-back
// Each interpolated result passes the back sequencer in S_LOOP (multiply), then S_ADD (add);
// each flushed tail result is made in S_FLUSH alone.
// A shared bit-serial divider computes the step after any rate write, the total on a last
// frame, and the skip over dropped outputs when a non-last frame hits 52 results.
// Reset clears all buffer state; the step is recomputed on the first frame after reset.
// A two-entry queue lets the input side accept while the back side stalls on m_tready.
module pcm_convert_linear_resampler
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // first_sample[15:0], second_sample[31:16]
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // left_out[15:0], right_out[31:16]
    output logic                           m_tlast,
    output logic                           m_tuser,   // buffer_end[0]
    input  logic                           cfg_en,
    input  logic [pcmr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pcmr_pkg::RATE_W-1:0]    cfg_data
);

    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_valid;
    pcmr_pkg::item_t q_in;
    pcmr_pkg::item_t q_head;
    pcmr_pkg::rate_t rates;

    pcmr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_in),
        .rates     (rates)
    );

    pcmr_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    pcmr_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_head),
        .q_pop    (q_pop),
        .rates    (rates),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ rtl/pcmr_front.sv @@
module pcmr_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,
    input  logic                              s_tlast,
    input  logic                              cfg_en,
    input  logic [pcmr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcmr_pkg::RATE_W-1:0]       cfg_data,
    input  logic                              q_full,
    output logic                              q_push,
    output pcmr_pkg::item_t                   q_item,
    output pcmr_pkg::rate_t                   rates
);

    logic                          wide_reg;
    logic                          stereo_reg;
    logic [pcmr_pkg::RATE_W-1:0]   rin_reg;
    logic [pcmr_pkg::RATE_W-1:0]   rout_reg;
    logic [pcmr_pkg::FRAME_W-1:0]  k_reg;
    logic [pcmr_pkg::FRAME_W-1:0]  k_next;
    logic [pcmr_pkg::SAMPLE_W-1:0] cl;
    logic [pcmr_pkg::SAMPLE_W-1:0] cr;
    logic                          last;

    function automatic logic [pcmr_pkg::SAMPLE_W-1:0] conv(input logic wide,
                                                           input logic [15:0] raw);
        logic [7:0] b;
        b = raw[7:0] ^ pcmr_pkg::U8_BIAS;
        return wide ? raw : {b, 8'h00};
    endfunction

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    assign cl   = conv(wide_reg, s_tdata[15:0]);
    assign cr   = stereo_reg ? conv(wide_reg, s_tdata[31:16]) : cl;
    assign last = s_tlast || (k_reg == pcmr_pkg::FRAME_W'(pcmr_pkg::MAX_FRAMES - 1));

    assign q_item.l    = $signed(cl);
    assign q_item.r    = $signed(cr);
    assign q_item.last = last;
    assign q_item.k    = k_reg;

    assign rates.rin  = (rin_reg == '0) ? pcmr_pkg::RATE_W'(1) : rin_reg;
    assign rates.rout = (rout_reg == '0) ? pcmr_pkg::RATE_W'(1) : rout_reg;
    assign rates.chg  = cfg_en && (cfg_index == pcmr_pkg::REG_IN_RATE ||
                                   cfg_index == pcmr_pkg::REG_OUT_RATE);

    always_comb
    begin
        k_next = k_reg;
        if (q_push)
        begin
            k_next = last ? '0 : k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg   <= 1'b1;
            stereo_reg <= 1'b1;
            rin_reg    <= pcmr_pkg::RATE_RESET;
            rout_reg   <= pcmr_pkg::RATE_RESET;
            k_reg      <= '0;
        end
        else
        begin
            k_reg <= k_next;
            if (cfg_en)
            begin
                unique case (cfg_index)
                    pcmr_pkg::REG_WIDE:     wide_reg   <= cfg_data[0];
                    pcmr_pkg::REG_STEREO:   stereo_reg <= cfg_data[0];
                    pcmr_pkg::REG_IN_RATE:  rin_reg    <= cfg_data;
                    pcmr_pkg::REG_OUT_RATE: rout_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ rtl/pcmr_fifo.sv @@
module pcmr_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pcmr_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output pcmr_pkg::item_t head
);

    localparam int AW = (pcmr_pkg::FIFO_DEPTH > 1) ? $clog2(pcmr_pkg::FIFO_DEPTH) : 1;
    localparam int CW = $clog2(pcmr_pkg::FIFO_DEPTH + 1);

    pcmr_pkg::item_t mem_reg [pcmr_pkg::FIFO_DEPTH];
    logic [AW-1:0]   wr_reg;
    logic [AW-1:0]   rd_reg;
    logic [CW-1:0]   cnt_reg;
    logic [AW-1:0]   wr_next;
    logic [AW-1:0]   rd_next;
    logic [CW-1:0]   cnt_next;

    assign full      = (cnt_reg == CW'(pcmr_pkg::FIFO_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == AW'(pcmr_pkg::FIFO_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == AW'(pcmr_pkg::FIFO_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ rtl/pcmr_div.sv @@
module pcmr_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pcmr_pkg::POS_W-1:0]    dividend,
    input  logic [pcmr_pkg::STEP_W-1:0]   divisor,
    output logic                          busy,
    output logic                          done,
    output logic [pcmr_pkg::POS_W-1:0]    quotient,
    output logic [pcmr_pkg::STEP_W-1:0]   remainder
);

    localparam int CNT_W = $clog2(pcmr_pkg::POS_W + 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [pcmr_pkg::POS_W-1:0]    quo_reg;
    logic [pcmr_pkg::STEP_W-1:0]   rem_reg;
    logic [pcmr_pkg::STEP_W-1:0]   dvs_reg;
    logic [pcmr_pkg::STEP_W:0]     trial;
    logic                          fits;

    assign trial = {rem_reg, quo_reg[pcmr_pkg::POS_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[pcmr_pkg::POS_W-2:0], fits};
            rem_reg <= fits ? pcmr_pkg::STEP_W'(trial - {1'b0, dvs_reg})
                            : pcmr_pkg::STEP_W'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(pcmr_pkg::POS_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ rtl/pcmr_back.sv @@
module pcmr_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  pcmr_pkg::item_t q_item,
    output logic            q_pop,
    input  pcmr_pkg::rate_t rates,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [31:0]     m_tdata,
    output logic            m_tlast,
    output logic            m_tuser
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_STEP   = 9'b000000010,
        S_TMUL   = 9'b000000100,
        S_TDIV   = 9'b000001000,
        S_LOOP   = 9'b000010000,
        S_ADD    = 9'b000100000,
        S_SKIP   = 9'b001000000,
        S_FLUSH  = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    localparam int SW = pcmr_pkg::SAMPLE_W;

    state_t                            state_reg, state_next;
    pcmr_pkg::item_t                   cur_reg, cur_next;
    logic [pcmr_pkg::STEP_W-1:0]       step_reg, step_next;
    logic                              step_ok_reg, step_ok_next;
    logic [pcmr_pkg::TOT_W-2:0]        tmul_reg, tmul_next;
    logic [pcmr_pkg::TOT_W-1:0]        total_reg, total_next;
    logic [pcmr_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [pcmr_pkg::EMIT_W-1:0]       emit_reg, emit_next;
    logic [pcmr_pkg::N_W-1:0]          n_reg, n_next;
    logic signed [SW-1:0]              held_l_reg, held_l_next;
    logic signed [SW-1:0]              held_r_reg, held_r_next;
    logic signed [2*SW+1:0]            mul_l_reg, mul_l_next;
    logic signed [2*SW+1:0]            mul_r_reg, mul_r_next;
    logic                              pend_valid_reg, pend_valid_next;
    logic signed [SW-1:0]              pend_l_reg, pend_l_next;
    logic signed [SW-1:0]              pend_r_reg, pend_r_next;
    logic                              out_valid_reg, out_valid_next;
    logic [31:0]                       out_data_reg, out_data_next;
    logic                              out_run_reg, out_run_next;
    logic                              out_buf_reg, out_buf_next;

    logic                              div_start;
    logic [pcmr_pkg::POS_W-1:0]        div_num;
    logic [pcmr_pkg::STEP_W-1:0]       div_den;
    logic                              div_busy;
    logic                              div_done;
    logic [pcmr_pkg::POS_W-1:0]        div_quo;
    logic [pcmr_pkg::STEP_W-1:0]       div_rem;

    logic                              out_free;
    logic                              pos_lt;
    logic                              n_ok;
    logic                              tot_ok;
    logic [pcmr_pkg::POS_W-1:0]        skip_num;
    logic signed [SW:0]                diff_l, diff_r;
    logic signed [SW:0]                frac_s;
    logic signed [SW+1:0]              q_l, q_r;
    logic signed [SW+1:0]              sum_l, sum_r;
    state_t                            work_state;

    pcmr_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_num),
        .divisor   (div_den),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign pos_lt   = pos_reg[pcmr_pkg::POS_W-1:pcmr_pkg::FRAC_W] <
                      pcmr_pkg::FRAC_W'(cur_reg.k);
    assign n_ok     = n_reg < pcmr_pkg::N_W'(pcmr_pkg::MAX_RESULTS);
    assign tot_ok   = emit_reg < pcmr_pkg::EMIT_W'(total_reg);
    assign skip_num = ({pcmr_pkg::FRAC_W'(cur_reg.k), pcmr_pkg::FRAC_W'(0)} - pos_reg)
                      + pcmr_pkg::POS_W'(step_reg) - 1'b1;

    assign frac_s = $signed({1'b0, pos_reg[pcmr_pkg::FRAC_W-1:pcmr_pkg::FRAC_W-SW]});
    assign diff_l = $signed({cur_reg.l[SW-1], cur_reg.l}) - $signed({held_l_reg[SW-1], held_l_reg});
    assign diff_r = $signed({cur_reg.r[SW-1], cur_reg.r}) - $signed({held_r_reg[SW-1], held_r_reg});
    assign q_l    = mul_l_reg[2*SW+1:SW];
    assign q_r    = mul_r_reg[2*SW+1:SW];
    assign sum_l  = $signed({{2{held_l_reg[SW-1]}}, held_l_reg}) + q_l;
    assign sum_r  = $signed({{2{held_r_reg[SW-1]}}, held_r_reg}) + q_r;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_run_reg;
    assign m_tuser  = out_buf_reg;

    always_comb
    begin
        if (cur_next.last)
        begin
            work_state = S_TMUL;
        end
        else if (cur_next.k != '0)
        begin
            work_state = S_LOOP;
        end
        else
        begin
            work_state = S_FINISH;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        step_next       = step_reg;
        step_ok_next    = step_ok_reg && !rates.chg;
        tmul_next       = tmul_reg;
        total_next      = total_reg;
        pos_next        = pos_reg;
        emit_next       = emit_reg;
        n_next          = n_reg;
        held_l_next     = held_l_reg;
        held_r_next     = held_r_reg;
        mul_l_next      = mul_l_reg;
        mul_r_next      = mul_r_reg;
        pend_valid_next = pend_valid_reg;
        pend_l_next     = pend_l_reg;
        pend_r_next     = pend_r_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_run_next    = out_run_reg;
        out_buf_next    = out_buf_reg;
        q_pop           = 1'b0;
        div_start       = 1'b0;
        div_num         = {pcmr_pkg::FRAC_W'(rates.rin), pcmr_pkg::FRAC_W'(0)};
        div_den         = pcmr_pkg::STEP_W'(rates.rout);

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    n_next   = '0;
                    if (!step_ok_reg)
                    begin
                        div_start  = 1'b1;
                        state_next = S_STEP;
                    end
                    else
                    begin
                        state_next = work_state;
                    end
                end
            end
            S_STEP:
            begin
                if (div_done)
                begin
                    step_next    = pcmr_pkg::STEP_W'(div_quo);
                    step_ok_next = 1'b1;
                    state_next   = work_state;
                end
            end
            S_TMUL:
            begin
                tmul_next  = (pcmr_pkg::TOT_W - 1)'((pcmr_pkg::FRAME_W + 1)'(cur_reg.k) + 1'b1)
                             * (pcmr_pkg::TOT_W - 1)'(rates.rout);
                state_next = S_TDIV;
            end
            S_TDIV:
            begin
                if (!div_busy && !div_done)
                begin
                    div_start = 1'b1;
                end
                div_num = pcmr_pkg::POS_W'(tmul_reg) + pcmr_pkg::POS_W'(rates.rin) - 1'b1;
                div_den = pcmr_pkg::STEP_W'(rates.rin);
                if (div_done)
                begin
                    total_next = pcmr_pkg::TOT_W'(div_quo);
                    state_next = (cur_reg.k != '0) ? S_LOOP : S_FLUSH;
                end
            end
            S_LOOP:
            begin
                if (pos_lt && n_ok && (!cur_reg.last || tot_ok))
                begin
                    mul_l_next = diff_l * frac_s;
                    mul_r_next = diff_r * frac_s;
                    pos_next   = pos_reg + pcmr_pkg::POS_W'(step_reg);
                    emit_next  = emit_reg + 1'b1;
                    n_next     = n_reg + 1'b1;
                    state_next = S_ADD;
                end
                else if (cur_reg.last)
                begin
                    state_next = S_FLUSH;
                end
                else if (pos_lt)
                begin
                    div_start  = 1'b1;
                    div_num    = skip_num;
                    div_den    = step_reg;
                    state_next = S_SKIP;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_ADD:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = {pend_r_reg, pend_l_reg};
                        out_run_next   = 1'b0;
                        out_buf_next   = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_l_next     = SW'(sum_l);
                    pend_r_next     = SW'(sum_r);
                    state_next      = S_LOOP;
                end
            end
            S_SKIP:
            begin
                if (div_done)
                begin
                    pos_next   = pos_reg + (skip_num - pcmr_pkg::POS_W'(div_rem));
                    emit_next  = emit_reg + pcmr_pkg::EMIT_W'(div_quo);
                    state_next = S_FINISH;
                end
            end
            S_FLUSH:
            begin
                if (tot_ok && n_ok)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = {pend_r_reg, pend_l_reg};
                            out_run_next   = 1'b0;
                            out_buf_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_l_next     = cur_reg.l;
                        pend_r_next     = cur_reg.r;
                        pos_next        = pos_reg + pcmr_pkg::POS_W'(step_reg);
                        emit_next       = emit_reg + 1'b1;
                        n_next          = n_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = {pend_r_reg, pend_l_reg};
                        out_run_next   = 1'b1;
                        out_buf_next   = cur_reg.last;
                    end
                    pend_valid_next = 1'b0;
                    if (cur_reg.last)
                    begin
                        held_l_next = '0;
                        held_r_next = '0;
                        pos_next    = '0;
                        emit_next   = '0;
                    end
                    else
                    begin
                        held_l_next = cur_reg.l;
                        held_r_next = cur_reg.r;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        step_reg     <= step_next;
        tmul_reg     <= tmul_next;
        total_reg    <= total_next;
        mul_l_reg    <= mul_l_next;
        mul_r_reg    <= mul_r_next;
        pend_l_reg   <= pend_l_next;
        pend_r_reg   <= pend_r_next;
        out_data_reg <= out_data_next;
        out_run_reg  <= out_run_next;
        out_buf_reg  <= out_buf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_ok_reg    <= 1'b0;
            pos_reg        <= '0;
            emit_reg       <= '0;
            n_reg          <= '0;
            held_l_reg     <= '0;
            held_r_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_ok_reg    <= step_ok_next;
            pos_reg        <= pos_next;
            emit_reg       <= emit_next;
            n_reg          <= n_next;
            held_l_reg     <= held_l_next;
            held_r_reg     <= held_r_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    a_n_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= pcmr_pkg::N_W'(pcmr_pkg::MAX_RESULTS))
        else $error("result count past limit");

    a_buf_end_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_buf_reg |-> out_run_reg)
        else $error("buffer end without run end");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && state_next == S_IDLE && cur_reg.last
        |=> pos_reg == '0 && emit_reg == '0)
        else $error("buffer state not cleared");

endmodule

@@ test/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 300;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        bit                 run_end;
        bit                 buf_end;
    } pcm_out_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;
    logic              m_tlast;
    logic              m_tuser;
    logic              cfg_en = 1'b0;
    logic [pcmr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [pcmr_pkg::RATE_W-1:0] cfg_data = '0;

    bit                   cfg_wide;
    bit                   cfg_stereo;
    longint unsigned      cfg_rin;
    longint unsigned      cfg_rout;
    int                   prev_l;
    int                   prev_r;
    longint unsigned      frame_count;
    longint unsigned      position;
    longint unsigned      emitted;
    longint unsigned      step;

    pcm_out_t expected_pcm[$];
    int       err_count;
    int       frames_sent;
    int       results_checked;
    int       buffers_done;
    int       sender_idle_pct;
    int       sink_stall_pct;
    int       quiet_cycles;

    pcm_convert_linear_resampler DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int to_pcm(logic [15:0] raw);
        if (cfg_wide)
            return int'($signed(raw));
        return (int'(raw[7:0]) - int'(pcmr_pkg::U8_BIAS)) * 256;
    endfunction

    function automatic int lerp(int a, int b, int unsigned f);
        longint v;
        v = longint'(b - a) * longint'(f);
        return a + int'(v >>> 16);
    endfunction

    function automatic void clear_buffer();
        prev_l = 0;
        prev_r = 0;
        frame_count = 0;
        position = 0;
        emitted = 0;
        step = 0;
    endfunction

    function automatic void predict_frame(logic [15:0] a, logic [15:0] b, bit last_in);
        longint unsigned rin;
        longint unsigned rout;
        longint unsigned k;
        longint unsigned total;
        longint unsigned gap;
        longint unsigned j;
        bit              last;
        int              cl;
        int              cr;
        int unsigned     f;
        pcm_out_t        outs[$];
        pcm_out_t        r;
        rin = (cfg_rin == 0) ? 1 : cfg_rin;
        rout = (cfg_rout == 0) ? 1 : cfg_rout;
        k = frame_count;
        last = last_in || (k + 1 >= pcmr_pkg::MAX_FRAMES);
        cl = to_pcm(a);
        cr = cfg_stereo ? to_pcm(b) : cl;
        total = 0;
        step = (rin << 32) / rout;
        if (last)
            total = ((k + 1) * rout + rin - 1) / rin;
        if (k > 0)
        begin
            while ((position >> 32) < k && outs.size() < pcmr_pkg::MAX_RESULTS &&
                   (!last || emitted < total))
            begin
                f = int'((position >> 16) & 64'hFFFF);
                r.left = 16'(lerp(prev_l, cl, f));
                r.right = 16'(lerp(prev_r, cr, f));
                r.run_end = 0;
                r.buf_end = 0;
                outs.push_back(r);
                position += step;
                emitted++;
            end
            if (!last && (position >> 32) < k)
            begin
                gap = (k << 32) - position;
                j = (gap + step - 1) / step;
                position += j * step;
                emitted += j;
            end
        end
        if (last)
        begin
            while (emitted < total && outs.size() < pcmr_pkg::MAX_RESULTS)
            begin
                r.left = 16'(cl);
                r.right = 16'(cr);
                r.run_end = 0;
                r.buf_end = 0;
                outs.push_back(r);
                position += step;
                emitted++;
            end
            if (outs.size() > 0)
            begin
                outs[outs.size()-1].run_end = 1;
                outs[outs.size()-1].buf_end = 1;
            end
            clear_buffer();
            buffers_done++;
        end
        else
        begin
            if (outs.size() > 0)
                outs[outs.size()-1].run_end = 1;
            prev_l = cl;
            prev_r = cr;
            frame_count = k + 1;
        end
        foreach (outs[i])
            expected_pcm.push_back(outs[i]);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d (result %0d)",
                 what, got, want, results_checked);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        pcm_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pcm.size() == 0)
            begin
                $display("unexpected result transfer %h", m_tdata);
                err_count++;
            end
            else
            begin
                want = expected_pcm.pop_front();
                if ($signed(m_tdata[15:0]) != want.left)
                    report_mismatch("left_out", $signed(m_tdata[15:0]), want.left);
                if ($signed(m_tdata[31:16]) != want.right)
                    report_mismatch("right_out", $signed(m_tdata[31:16]), want.right);
                if (m_tlast != want.run_end)
                    report_mismatch("run_end", m_tlast, want.run_end);
                if (m_tuser != want.buf_end)
                    report_mismatch("buffer_end", m_tuser, want.buf_end);
            end
            results_checked++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results pending", expected_pcm.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_frame(logic [15:0] a, logic [15:0] b, bit last);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, a};
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_frame(a, b, last);
        frames_sent++;
    endtask

    // hold off input until all results are back, then let the divider finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_pcm.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(bit wide, bit stereo, int unsigned rin, int unsigned rout);
        cfg_en <= 1'b1;
        cfg_index <= pcmr_pkg::REG_WIDE;
        cfg_data <= pcmr_pkg::RATE_W'(wide);
        @(posedge clk);
        cfg_index <= pcmr_pkg::REG_STEREO;
        cfg_data <= pcmr_pkg::RATE_W'(stereo);
        @(posedge clk);
        cfg_index <= pcmr_pkg::REG_IN_RATE;
        cfg_data <= pcmr_pkg::RATE_W'(rin);
        @(posedge clk);
        cfg_index <= pcmr_pkg::REG_OUT_RATE;
        cfg_data <= pcmr_pkg::RATE_W'(rout);
        @(posedge clk);
        cfg_en <= 1'b0;
        cfg_wide = wide;
        cfg_stereo = stereo;
        cfg_rin = rin & 18'h3FFFF;
        cfg_rout = rout & 18'h3FFFF;
    endtask

    function automatic int unsigned pick_rate();
        case ($urandom_range(11))
            0: return 8000;
            1: return 192000;
            2: return 44100;
            3: return 48000;
            4: return 0;
            5: return 262143;
            default: return $urandom_range(8000, 192000);
        endcase
    endfunction

    task automatic test_directed();
        sender_idle_pct = 0;
        sink_stall_pct = 0;
        send_frame(16'h1234, 16'hFEDC, 1);
        send_frame(16'h0000, 16'hFFFF, 0);
        send_frame(16'h7FFF, 16'h8000, 0);
        send_frame(16'h8000, 16'h7FFF, 0);
        send_frame(16'hFFFF, 16'h0000, 1);
        settle();
        write_config(0, 0, 8000, 192000);
        send_frame(16'h00FF, 16'hAAAA, 0);
        send_frame(16'hFF00, 16'h5555, 0);
        send_frame(16'h0080, 16'h0000, 1);
        settle();
        write_config(1, 1, 192000, 8000);
        send_frame(16'h4000, 16'hC000, 0);
        send_frame(16'hC000, 16'h4000, 0);
        send_frame(16'h0001, 16'hFFFE, 1);
        settle();
        write_config(1, 0, 0, 192000);
        send_frame(16'h7FFF, 16'h0000, 0);
        send_frame(16'h8000, 16'h0000, 0);
        send_frame(16'h0100, 16'h0000, 1);
        settle();
        write_config(1, 1, 192000, 0);
        send_frame(16'h1111, 16'h2222, 0);
        send_frame(16'h3333, 16'h4444, 1);
        settle();
        write_config(1, 1, 11025, 48000);
        send_frame(16'h8001, 16'h7FFE, 0);
        send_frame(16'h2000, 16'hE000, 0);
        settle();
        // change rate and format in the middle of a buffer
        write_config(0, 1, 48000, 22050);
        send_frame(16'h00C0, 16'h0040, 0);
        send_frame(16'h0010, 16'h00F0, 1);
        settle();
    endtask

    task automatic test_random(int items, int idle_pct, int stall_pct);
        int sent;
        int len;
        sender_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(3) != 0)
            begin
                settle();
                write_config($urandom_range(1), $urandom_range(1), pick_rate(), pick_rate());
            end
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                send_frame(16'($urandom), 16'($urandom), i == len - 1);
                if (i == 1 && len > 3 && $urandom_range(4) == 0)
                begin
                    settle();
                    write_config($urandom_range(1), $urandom_range(1),
                                 pick_rate(), pick_rate());
                end
            end
            sent += len;
        end
    endtask

    initial
    begin
        err_count = 0;
        frames_sent = 0;
        results_checked = 0;
        buffers_done = 0;
        quiet_cycles = 0;
        sender_idle_pct = 0;
        sink_stall_pct = 0;
        cfg_wide = 1;
        cfg_stereo = 1;
        cfg_rin = 44100;
        cfg_rout = 44100;
        clear_buffer();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(48, 0, 0);
        test_random(48, 51, 0);
        test_random(48, 0, 51);
        test_random(48, 38, 38);
        settle();
        $display("covered %0d frames in %0d buffers, %0d results checked",
                 frames_sent, buffers_done, results_checked);
        $display("formats, rate extremes and zero rates under four idling mixes");
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
